@@ sv/bxds_pkg.sv @@
package bxds_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ROW_W   = 13;
  localparam int unsigned CC_W    = 3;
  localparam int unsigned IDX_W   = 2;

  typedef logic [IDX_W-1:0] cfg_index_t;
  typedef logic [DIM_W-1:0] cfg_data_t;

  localparam cfg_index_t REG_SRC_WIDTH     = 2'd0;
  localparam cfg_index_t REG_SRC_HEIGHT    = 2'd1;
  localparam cfg_index_t REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0] SRC_WIDTH_RESET     = 13'd4096;
  localparam logic [DIM_W-1:0] SRC_HEIGHT_RESET    = 13'd4096;
  localparam logic [CC_W-1:0]  CHANNEL_COUNT_RESET = 3'd1;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_word_t;

  typedef struct packed {
    logic              odd_col;
    logic              odd_row;
    logic [NUM_CH-1:0] lane_en;
    sum_word_t         near;
    logic              row_end;
    logic              frame_end;
  } blk_info_t;

endpackage

@@ sv/bxds_pix_in_if.sv @@
interface bxds_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_ch0;
  logic [7:0] in_ch1;
  logic [7:0] in_ch2;
  logic [7:0] in_ch3;

  modport source (output valid, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
  modport sink (input valid, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

@@ sv/bxds_pix_out_if.sv @@
interface bxds_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch0;
  logic [7:0] out_ch1;
  logic [7:0] out_ch2;
  logic [7:0] out_ch3;
  logic       row_end;
  logic       frame_end;

  modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, row_end, frame_end,
                  input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, row_end, frame_end,
                output ready);
endinterface

@@ sv/bxds_cfg_if.sv @@
interface bxds_cfg_if;
  logic                  valid;
  logic                  ready;
  bxds_pkg::cfg_index_t  index;
  bxds_pkg::cfg_data_t   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/bxds_avg.sv @@
module bxds_avg (
  input  bxds_pkg::blk_info_t info,
  input  bxds_pkg::sum_word_t above,
  output bxds_pkg::pixel_t    result
);

  always_comb begin
    logic [bxds_pkg::SUM_W-1:0] up;
    logic [bxds_pkg::SUM_W:0]   sum;
    for (int c = 0; c < bxds_pkg::NUM_CH; c++) begin
      up  = info.odd_row ? above[c] : info.near[c];
      sum = (bxds_pkg::SUM_W+1)'(up) + (bxds_pkg::SUM_W+1)'(info.near[c])
          + (info.odd_col ? 11'd2 : 11'd1);
      if (!info.lane_en[c]) begin
        result[c] = '0;
      end else if (info.odd_col) begin
        result[c] = sum[9:2];
      end else begin
        result[c] = sum[8:1];
      end
    end
  end

endmodule

@@ sv/image_2x2_box_downscale_unit.sv @@
// Channel  Role                 Handshake      Payload
// src      source pixels in     valid / ready  in_ch0..in_ch3
// dst      reduced pixels out   valid / ready  out_ch0..out_ch3, row_end, frame_end
// cfg      register writes      valid / ready  index, data
//
// One pixel is taken per clock while src.ready is high; results pass s1_info, then out_pix.
// The rate is set by the single line-buffer memory: at most one read or one write per pixel.
// Reset is synchronous; the line buffer is not cleared and needs no clearing pass.
// A stalled output holds the two-stage pipeline; src.ready drops only when both stages are full.
module image_2x2_box_downscale_unit #(
  parameter int MAX_SRC_WIDTH = 4096
) (
  input logic             clk,
  input logic             rst,
  bxds_pix_in_if.sink     src,
  bxds_pix_out_if.source  dst,
  bxds_cfg_if.sink        cfg
);

  localparam int CW         = $clog2(MAX_SRC_WIDTH);
  localparam int LINE_DEPTH = (MAX_SRC_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int XW         = ((CW > bxds_pkg::DIM_W) ? CW : bxds_pkg::DIM_W) + 1;

  logic [bxds_pkg::DIM_W-1:0] src_width;
  logic [bxds_pkg::DIM_W-1:0] src_height;
  logic [bxds_pkg::CC_W-1:0]  channel_count;

  logic [CW-1:0]              col;
  logic [bxds_pkg::ROW_W-1:0] row;
  bxds_pkg::pixel_t           held;

  bxds_pkg::sum_word_t        line_mem [LINE_DEPTH];
  bxds_pkg::sum_word_t        above;

  logic                       s1_valid;
  bxds_pkg::blk_info_t        s1_info;
  bxds_pkg::blk_info_t        s1_next;
  bxds_pkg::pixel_t           avg;

  logic                       out_valid;
  bxds_pkg::pixel_t           out_pix;
  logic                       out_row_end;
  logic                       out_frame_end;

  logic                       en1, en2, in_fire;
  logic [XW-1:0]              w_ext, w_eff, col_plus;
  logic [bxds_pkg::DIM_W-1:0] h_eff;
  logic [bxds_pkg::DIM_W:0]   row_plus;
  logic [bxds_pkg::CC_W-1:0]  cc_eff;
  logic                       last_col, last_row, odd_col, odd_row;
  logic                       hold, wr, emit;
  logic [AW-1:0]              idx;
  logic [bxds_pkg::NUM_CH-1:0] lane_en;
  bxds_pkg::pixel_t           pix;
  bxds_pkg::sum_word_t        near;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= bxds_pkg::SRC_WIDTH_RESET;
      src_height    <= bxds_pkg::SRC_HEIGHT_RESET;
      channel_count <= bxds_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bxds_pkg::REG_SRC_WIDTH:     src_width     <= cfg.data;
        bxds_pkg::REG_SRC_HEIGHT:    src_height    <= cfg.data;
        bxds_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[bxds_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign en2     = !out_valid || dst.ready;
  assign en1     = !s1_valid || en2;
  assign in_fire = src.valid && en1;
  assign src.ready = en1;

  always_comb begin
    w_ext = XW'(src_width);
    if (w_ext == '0) begin
      w_eff = XW'(1);
    end else if (w_ext > XW'(MAX_SRC_WIDTH)) begin
      w_eff = XW'(MAX_SRC_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff    = (src_height == '0) ? bxds_pkg::DIM_W'(1) : src_height;
    cc_eff   = (channel_count == '0) ? 3'd1 : ((channel_count > 3'd4) ? 3'd4 : channel_count);
    col_plus = XW'(col) + XW'(1);
    row_plus = {1'b0, row} + (bxds_pkg::DIM_W+1)'(1);
    last_col = col_plus >= w_eff;
    last_row = row_plus >= {1'b0, h_eff};
    odd_col  = col[0];
    odd_row  = row[0];
    idx      = AW'(col >> 1);
    hold     = !odd_col && !last_col;
    wr       = !hold && !odd_row && !last_row;
    emit     = !hold && !wr;
    pix[0] = src.in_ch0;
    pix[1] = src.in_ch1;
    pix[2] = src.in_ch2;
    pix[3] = src.in_ch3;
    for (int c = 0; c < bxds_pkg::NUM_CH; c++) begin
      lane_en[c] = bxds_pkg::CC_W'(c) < cc_eff;
      if (!lane_en[c]) begin
        pix[c] = '0;
      end
      near[c] = odd_col ? bxds_pkg::SUM_W'(held[c]) + bxds_pkg::SUM_W'(pix[c])
                        : bxds_pkg::SUM_W'(pix[c]);
    end
    s1_next.odd_col   = odd_col;
    s1_next.odd_row   = odd_row;
    s1_next.lane_en   = lane_en;
    s1_next.near      = near;
    s1_next.row_end   = last_col;
    s1_next.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      held <= '0;
    end else if (in_fire) begin
      if (hold) begin
        held <= pix;
      end
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row_plus[bxds_pkg::ROW_W-1:0];
      end else begin
        col <= col_plus[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && wr) begin
      line_mem[idx] <= near;
    end
    if (in_fire && emit) begin
      above <= line_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= in_fire && emit;
      end
      if (en2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      s1_info <= s1_next;
    end
    if (en2 && s1_valid) begin
      out_pix       <= avg;
      out_row_end   <= s1_info.row_end;
      out_frame_end <= s1_info.frame_end;
    end
  end

  bxds_avg u_avg (
    .info   (s1_info),
    .above  (above),
    .result (avg)
  );

  assign dst.valid     = out_valid;
  assign dst.out_ch0   = out_pix[0];
  assign dst.out_ch1   = out_pix[1];
  assign dst.out_ch2   = out_pix[2];
  assign dst.out_ch3   = out_pix[3];
  assign dst.row_end   = out_row_end;
  assign dst.frame_end = out_frame_end;

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en2 |=> s1_valid && $stable(s1_info))
    else $error("Stage one lost its block while the output was stalled.");

  a_s1_empty: assert property (@(posedge clk) disable iff (rst)
    en1 && !(in_fire && emit) |=> !s1_valid)
    else $error("Stage one filled without an emitting transfer.");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_col |=> col == '0)
    else $error("Column position did not wrap after the last column.");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_row_end)
    else $error("Frame end flagged without row end.");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !(wr && emit))
    else $error("Line buffer read and written by the same transfer.");
`endif

endmodule

@@ test/image_2x2_box_downscale_unit_tb.sv @@
`timescale 1ns / 1ps

module image_2x2_box_downscale_unit_tb;

  localparam int unsigned MAX_SRC_WIDTH = 4096;
  localparam int unsigned LINE_ENTRIES  = (MAX_SRC_WIDTH + 1) / 2;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned END_LIMIT     = 100000;
  localparam int unsigned RANDOM_ITEMS  = 520;
  localparam bxds_pkg::cfg_index_t REG_SPARE = 2'd3;

  typedef struct packed {
    bxds_pkg::pixel_t ch;
    logic             row_end;
    logic             frame_end;
  } box_result_t;

  logic clk;
  logic rst;

  bxds_pix_in_if  src_if();
  bxds_pix_out_if dst_if();
  bxds_cfg_if     cfg_if();

  image_2x2_box_downscale_unit #(
    .MAX_SRC_WIDTH(MAX_SRC_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .src(src_if),
    .dst(dst_if),
    .cfg(cfg_if)
  );

  logic [bxds_pkg::DIM_W-1:0] model_width;
  logic [bxds_pkg::DIM_W-1:0] model_height;
  logic [bxds_pkg::CC_W-1:0]  model_channels;
  bxds_pkg::sum_word_t        line_sums [LINE_ENTRIES];
  bxds_pkg::pixel_t           held_pixel;
  int unsigned                pos_col;
  int unsigned                pos_row;

  box_result_t pending_boxes[$];
  int unsigned error_count;
  int unsigned pixels_sent;
  bit          no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("image_2x2_box_downscale_unit_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic bit predict_box(input bxds_pkg::pixel_t px, output box_result_t r);
    int unsigned         w, h, cc, idx, pair, up, p;
    logic                last_col, last_row, odd_col, odd_row;
    bxds_pkg::pixel_t    pix;
    bxds_pkg::sum_word_t v, above;
    bit                  produced;
    w  = model_width;
    h  = model_height;
    cc = model_channels;
    if (w < 1) w = 1;
    if (w > MAX_SRC_WIDTH) w = MAX_SRC_WIDTH;
    if (h < 1) h = 1;
    if (cc < 1) cc = 1;
    if (cc > bxds_pkg::NUM_CH) cc = bxds_pkg::NUM_CH;
    pix = '0;
    for (int c = 0; c < cc; c++) pix[c] = px[c];
    r        = '0;
    produced = 1'b0;
    last_col = (pos_col + 1 >= w);
    last_row = (pos_row + 1 >= h);
    odd_col  = pos_col[0];
    odd_row  = pos_row[0];
    idx      = pos_col >> 1;
    if (!odd_col && !last_col) begin
      held_pixel = pix;
    end else if (!odd_row && !last_row) begin
      for (int c = 0; c < bxds_pkg::NUM_CH; c++) begin
        v[c] = bxds_pkg::SUM_W'(pix[c])
             + (odd_col ? bxds_pkg::SUM_W'(held_pixel[c]) : bxds_pkg::SUM_W'(0));
      end
      line_sums[idx] = v;
    end else begin
      above = line_sums[idx];
      for (int c = 0; c < cc; c++) begin
        p = pix[c];
        if (odd_col) begin
          pair = held_pixel[c] + p;
          up = odd_row ? int'(above[c]) : pair;
          r.ch[c] = bxds_pkg::CH_W'((up + pair + 2) >> 2);
        end else begin
          up = odd_row ? int'(above[c]) : p;
          r.ch[c] = bxds_pkg::CH_W'((up + p + 1) >> 1);
        end
      end
      r.row_end   = last_col;
      r.frame_end = last_col && last_row;
      produced    = 1'b1;
    end
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return produced;
  endfunction

  task automatic wait_idle();
    src_if.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bxds_pkg::cfg_index_t index, input int unsigned value);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= bxds_pkg::cfg_data_t'(value);
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    case (index)
      bxds_pkg::REG_SRC_WIDTH:     model_width = bxds_pkg::cfg_data_t'(value);
      bxds_pkg::REG_SRC_HEIGHT:    model_height = bxds_pkg::cfg_data_t'(value);
      bxds_pkg::REG_CHANNEL_COUNT: model_channels = bxds_pkg::CC_W'(value);
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned cc);
    write_reg(bxds_pkg::REG_SRC_WIDTH, w);
    write_reg(bxds_pkg::REG_SRC_HEIGHT, h);
    write_reg(bxds_pkg::REG_CHANNEL_COUNT, cc);
  endtask

  task automatic send_pixel(input bxds_pkg::pixel_t px);
    int unsigned gap;
    box_result_t r;
    gap = draw_gap();
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_if.valid  <= 1'b1;
    src_if.in_ch0 <= px[0];
    src_if.in_ch1 <= px[1];
    src_if.in_ch2 <= px[2];
    src_if.in_ch3 <= px[3];
    @(posedge clk);
    while (src_if.ready !== 1'b1) @(posedge clk);
    if (predict_box(px, r)) pending_boxes.push_back(r);
    pixels_sent++;
  endtask

  function automatic bxds_pkg::pixel_t random_pixel();
    bxds_pkg::pixel_t px;
    for (int c = 0; c < bxds_pkg::NUM_CH; c++) px[c] = bxds_pkg::CH_W'($urandom_range(0, 255));
    return px;
  endfunction

  task automatic send_frame();
    int unsigned w, h;
    w = model_width;
    h = model_height;
    if (w < 1) w = 1;
    if (w > MAX_SRC_WIDTH) w = MAX_SRC_WIDTH;
    if (h < 1) h = 1;
    repeat (w * h) send_pixel(random_pixel());
  endtask

  // Only the dimensions are written, so the channel count keeps its reset value.
  task automatic test_reset_channel_count();
    write_reg(bxds_pkg::REG_SRC_WIDTH, 2);
    write_reg(bxds_pkg::REG_SRC_HEIGHT, 2);
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h55, 8'hAA, 8'h0F, 8'hFF});
    send_pixel({8'hAA, 8'h55, 8'hF0, 8'hFF});
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_sample_extremes();
    configure(2, 2, 4);
    repeat (4) send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel({8'h00, 8'h01, 8'h02, 8'h03});
    send_pixel({8'h00, 8'h00, 8'h00, 8'hFF});
    send_pixel({8'hAA, 8'h55, 8'h00, 8'h00});
    send_pixel({8'h55, 8'hAA, 8'h00, 8'h01});
  endtask

  task automatic test_odd_dimensions();
    configure(3, 3, 4);
    send_frame();
  endtask

  task automatic test_clamped_registers();
    configure(0, 0, 0);
    write_reg(REG_SPARE, $urandom_range(0, 8191));
    send_pixel(random_pixel());
    write_reg(bxds_pkg::REG_CHANNEL_COUNT, 7);
    send_pixel(random_pixel());
  endtask

  task automatic test_extreme_dimensions();
    configure(1, 48, 4);
    send_frame();
    configure(48, 1, $urandom_range(0, 7));
    send_frame();
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    while (pixels_sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 24);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      configure(w, h, $urandom_range(0, 7));
      no_idle = ($urandom_range(0, 4) == 0);
      send_frame();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    box_result_t      exp;
    bxds_pkg::pixel_t got;
    int unsigned      gap;
    dst_if.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        dst_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dst_if.ready <= 1'b1;
      @(posedge clk);
      while (dst_if.valid !== 1'b1) @(posedge clk);
      got = {dst_if.out_ch3, dst_if.out_ch2, dst_if.out_ch1, dst_if.out_ch0};
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        exp = pending_boxes.pop_front();
        for (int c = 0; c < bxds_pkg::NUM_CH; c++) begin
          if (got[c] !== exp.ch[c]) begin
            report_mismatch($sformatf("out_ch%0d got %h expected %h", c, got[c], exp.ch[c]));
          end
        end
        if (dst_if.row_end !== exp.row_end) begin
          report_mismatch($sformatf("row_end got %b expected %b", dst_if.row_end, exp.row_end));
        end
        if (dst_if.frame_end !== exp.frame_end) begin
          report_mismatch($sformatf("frame_end got %b expected %b",
                                    dst_if.frame_end, exp.frame_end));
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    rst           <= 1'b1;
    src_if.valid  <= 1'b0;
    src_if.in_ch0 <= '0;
    src_if.in_ch1 <= '0;
    src_if.in_ch2 <= '0;
    src_if.in_ch3 <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= bxds_pkg::REG_SRC_WIDTH;
    cfg_if.data   <= '0;
    model_width    = bxds_pkg::SRC_WIDTH_RESET;
    model_height   = bxds_pkg::SRC_HEIGHT_RESET;
    model_channels = bxds_pkg::CHANNEL_COUNT_RESET;
    held_pixel     = '0;
    pos_col        = 0;
    pos_row        = 0;
    error_count    = 0;
    pixels_sent    = 0;
    no_idle        = 1'b0;
    for (int i = 0; i < LINE_ENTRIES; i++) line_sums[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_channel_count();
    test_sample_extremes();
    test_odd_dimensions();
    test_clamped_registers();
    test_extreme_dimensions();
    test_random_frames();

    src_if.valid <= 1'b0;
    waited = 0;
    while (pending_boxes.size() != 0 && waited < END_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_boxes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_boxes.size()));
    end
    if (error_count == 0) begin
      $display("image_2x2_box_downscale_unit_tb OK");
    end else begin
      $display("image_2x2_box_downscale_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
